// File: sv/tfi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfi_pkg
// Shared types and constants of the trilinear field interpolator.
// ----------------------------------------------------------------------------
package tfi_pkg;

	localparam int POS_BITS     = 32;
	localparam int STEP_BITS    = 32;
	localparam int AXIS_BITS    = 10;
	localparam int ADDR_IN_BITS = 15;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_BITS     = 32;
	localparam int CORNERS      = 8;
	localparam int COMPONENTS   = 6;
	localparam int LIN_BITS     = 31;
	localparam int PLANE_BITS   = 2 * AXIS_BITS;
	localparam int OFF_BITS     = PLANE_BITS + 1;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	localparam logic [CFG_IDX_BITS-1:0] CFG_GRID_COUNTS = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_X    = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Y    = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] CFG_ORIGIN_Z    = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INV_STEP_X  = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INV_STEP_Y  = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INV_STEP_Z  = 3'd6;

	localparam logic [STEP_BITS-1:0] INV_STEP_RESET = 32'h0001_0000;

	typedef struct packed {
		logic signed [POS_BITS-1:0] origin;
		logic [STEP_BITS-1:0]       inv_step;
		logic [AXIS_BITS-1:0]       count;
	} axis_cfg_t;

	typedef struct packed {
		logic                 ok;
		logic [AXIS_BITS-1:0] idx;
	} axis_cell_t;

endpackage
`default_nettype wire

// File: sv/tfi_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfi_if
// Request and response channels of the trilinear field interpolator.
// ----------------------------------------------------------------------------
interface tfi_req_if #(parameter int SAMPLE_BITS = 24);
	logic                                   valid;
	logic                                   ready;
	logic                                   opcode;
	logic [tfi_pkg::ADDR_IN_BITS-1:0]       sample_address;
	logic signed [SAMPLE_BITS-1:0]          sample_ex;
	logic signed [SAMPLE_BITS-1:0]          sample_ey;
	logic signed [SAMPLE_BITS-1:0]          sample_ez;
	logic signed [SAMPLE_BITS-1:0]          sample_hx;
	logic signed [SAMPLE_BITS-1:0]          sample_hy;
	logic signed [SAMPLE_BITS-1:0]          sample_hz;
	logic signed [tfi_pkg::POS_BITS-1:0]    pos_x;
	logic signed [tfi_pkg::POS_BITS-1:0]    pos_y;
	logic signed [tfi_pkg::POS_BITS-1:0]    pos_z;

	modport source (output valid, opcode, sample_address, sample_ex, sample_ey, sample_ez,
		sample_hx, sample_hy, sample_hz, pos_x, pos_y, pos_z, input ready);
	modport sink (input valid, opcode, sample_address, sample_ex, sample_ey, sample_ez,
		sample_hx, sample_hy, sample_hz, pos_x, pos_y, pos_z, output ready);
endinterface

interface tfi_rsp_if #(parameter int SAMPLE_BITS = 24);
	logic                          valid;
	logic                          ready;
	logic                          in_range;
	logic signed [SAMPLE_BITS-1:0] e_x_out;
	logic signed [SAMPLE_BITS-1:0] e_y_out;
	logic signed [SAMPLE_BITS-1:0] e_z_out;
	logic signed [SAMPLE_BITS-1:0] b_x_out;
	logic signed [SAMPLE_BITS-1:0] b_y_out;
	logic signed [SAMPLE_BITS-1:0] b_z_out;

	modport source (output valid, in_range, e_x_out, e_y_out, e_z_out,
		b_x_out, b_y_out, b_z_out, input ready);
	modport sink (input valid, in_range, e_x_out, e_y_out, e_z_out,
		b_x_out, b_y_out, b_z_out, output ready);
endinterface
`default_nettype wire

// File: sv/tfi_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfi_ram
// Generic single-address RAM with registered read.
// ----------------------------------------------------------------------------
module tfi_ram #(
	parameter int WIDTH = 144,
	parameter int DEPTH = 32768
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end
endmodule
`default_nettype wire

// File: sv/tfi_locate.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfi_locate
// One axis lane: offset, scale, split into cell index and fraction, range check.
// ----------------------------------------------------------------------------
module tfi_locate #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                en,
	input  wire tfi_pkg::axis_cfg_t                  cfg,
	input  wire logic signed [tfi_pkg::POS_BITS-1:0] pos,
	output tfi_pkg::axis_cell_t                      cell_s3,
	output logic [FRAC_BITS-1:0]                     frac_s3
);
	import tfi_pkg::*;

	localparam int PROD_BITS = POS_BITS + STEP_BITS;

	logic signed [POS_BITS:0] diff_s1;
	logic [PROD_BITS-1:0]     prod_c;
	logic [PROD_BITS-1:0]     prod_s2;
	logic                     bad_s2;
	logic [POS_BITS-1:0]      idx_c;

	assign prod_c = PROD_BITS'(diff_s1[POS_BITS-1:0]) * PROD_BITS'(cfg.inv_step);
	assign idx_c  = prod_s2[PROD_BITS-1 -: POS_BITS];

	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= {pos[POS_BITS-1], pos} - {cfg.origin[POS_BITS-1], cfg.origin};
			// below the origin only a zero scale keeps the point (at cell 0)
			if (diff_s1[POS_BITS]) begin
				prod_s2 <= '0;
				bad_s2  <= |cfg.inv_step;
			end else begin
				prod_s2 <= prod_c;
				bad_s2  <= 1'b0;
			end
			cell_s3.idx <= idx_c[AXIS_BITS-1:0];
			cell_s3.ok  <= !bad_s2 && (idx_c[POS_BITS-1:AXIS_BITS] == '0) &&
				(({1'b0, idx_c[AXIS_BITS-1:0]} + (AXIS_BITS+1)'(2)) <= {1'b0, cfg.count});
			frac_s3 <= prod_s2[STEP_BITS-1 -: FRAC_BITS];
		end
	end
endmodule
`default_nettype wire

// File: sv/tfi_lerp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfi_lerp
// Registered linear blend of two samples, rounded half toward plus infinity.
// ----------------------------------------------------------------------------
module tfi_lerp #(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [SAMPLE_BITS-1:0] a,
	input  wire logic signed [SAMPLE_BITS-1:0] b,
	input  wire logic [FRAC_BITS-1:0]          f,
	output logic signed [SAMPLE_BITS-1:0]      y
);
	localparam int W = SAMPLE_BITS + FRAC_BITS + 2;
	localparam logic signed [W-1:0] HALF = W'(1) <<< (FRAC_BITS - 1);

	logic signed [SAMPLE_BITS:0] delta;
	logic signed [FRAC_BITS:0]   fs;
	logic signed [W-1:0]         prod;
	logic signed [W-1:0]         base;
	logic signed [W-1:0]         sum;

	assign delta = {b[SAMPLE_BITS-1], b} - {a[SAMPLE_BITS-1], a};
	assign fs    = {1'b0, f};
	assign prod  = delta * fs;
	assign base  = {{2{a[SAMPLE_BITS-1]}}, a, {FRAC_BITS{1'b0}}};
	assign sum   = base + prod + HALF;

	always_ff @(posedge clk) begin
		if (en) begin
			y <= sum[FRAC_BITS +: SAMPLE_BITS];
		end
	end
endmodule
`default_nettype wire

// File: sv/tfi_blend.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tfi_blend
// One component lane: blend eight corners along x, then y, then z.
// ----------------------------------------------------------------------------
module tfi_blend #(
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [SAMPLE_BITS-1:0] corner [tfi_pkg::CORNERS],
	input  wire logic [FRAC_BITS-1:0]          fx,
	input  wire logic [FRAC_BITS-1:0]          fy,
	input  wire logic [FRAC_BITS-1:0]          fz,
	output logic signed [SAMPLE_BITS-1:0]      res
);
	logic signed [SAMPLE_BITS-1:0] ax_s8 [4];
	logic signed [SAMPLE_BITS-1:0] by_s9 [2];

	for (genvar c = 0; c < 4; c++) begin : g_x
		tfi_lerp #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lx (
			.clk(clk), .en(en), .a(corner[2*c]), .b(corner[2*c+1]), .f(fx), .y(ax_s8[c]));
	end
	for (genvar c = 0; c < 2; c++) begin : g_y
		tfi_lerp #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_ly (
			.clk(clk), .en(en), .a(ax_s8[2*c]), .b(ax_s8[2*c+1]), .f(fy), .y(by_s9[c]));
	end
	tfi_lerp #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_lz (
		.clk(clk), .en(en), .a(by_s9[0]), .b(by_s9[1]), .f(fz), .y(res));
endmodule
`default_nettype wire

// File: sv/trilinear_field_interpolator_unit.sv
// A query passes pipe stages s1 to s10 to the result word; writes give no result.
// Throughput: one word per cycle, set by the eight corner copies of the sample
// store, each read at one address per cycle. A stalled result stalls the whole pipe.
// Writes land in all copies from stage s6, in order with queries.
// Reset clears valid bits, counts and origins, presets inverse steps; store kept.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// trilinear_field_interpolator_unit
// Six-component 3D grid store with pipelined trilinear interpolation.
// ----------------------------------------------------------------------------
module trilinear_field_interpolator_unit #(
	parameter int GRID_DEPTH  = 32768,
	parameter int SAMPLE_BITS = 24,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tfi_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [tfi_pkg::CFG_BITS-1:0]        cfg_data,
	tfi_req_if.sink                                  req,
	tfi_rsp_if.source                                rsp
);
	import tfi_pkg::*;

	localparam int AW = $clog2(GRID_DEPTH);
	localparam int DW = COMPONENTS * SAMPLE_BITS;

	// configuration
	logic [3*AXIS_BITS-1:0]     grid_counts_q;
	logic signed [POS_BITS-1:0] origin_q [3];
	logic [STEP_BITS-1:0]       inv_q [3];
	logic [AXIS_BITS-1:0]       nx, ny, nz;
	logic [PLANE_BITS-1:0]      plane_q;
	logic [OFF_BITS-1:0]        corner_off_q [CORNERS];
	axis_cfg_t                  acfg [3];

	logic adv;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic q_s1, q_s2, q_s3, q_s4, q_s5, q_s6;
	logic [ADDR_IN_BITS-1:0] waddr_s1, waddr_s2, waddr_s3, waddr_s4, waddr_s5, waddr_s6;
	logic [DW-1:0] wdata_s1, wdata_s2, wdata_s3, wdata_s4, wdata_s5, wdata_s6;

	axis_cell_t            cell_s3 [3];
	logic [FRAC_BITS-1:0]  frac_s3 [3];
	logic [FRAC_BITS-1:0]  fx_s4, fy_s4, fz_s4, fx_s5, fy_s5, fz_s5, fx_s6, fy_s6, fz_s6;
	logic [FRAC_BITS-1:0]  fx_s7, fy_s7, fz_s7, fy_s8, fz_s8, fz_s9;
	logic [AXIS_BITS-1:0]  ix_s4, iy_s4, ix_s5;
	logic [PLANE_BITS-1:0] zy_s4;
	logic [LIN_BITS-1:0]   row_s5, base_s6;
	logic ok_s4, ok_s5, ok_s6, ok_s7, ok_s8, ok_s9, ok_s10;

	logic [LIN_BITS-1:0]     offs [CORNERS];
	logic                    cell_fits;
	logic [AW+ADDR_IN_BITS-1:0] waddr_ext;
	logic [LIN_BITS+AW-1:0]  far_ext;
	logic                    ram_we;
	logic [DW-1:0]           ram_q [CORNERS];
	logic signed [SAMPLE_BITS-1:0] res_s10 [COMPONENTS];

	assign nx = grid_counts_q[AXIS_BITS-1:0];
	assign ny = grid_counts_q[2*AXIS_BITS-1:AXIS_BITS];
	assign nz = grid_counts_q[3*AXIS_BITS-1:2*AXIS_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_counts_q <= '0;
			origin_q      <= '{default: '0};
			inv_q         <= '{default: INV_STEP_RESET};
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_GRID_COUNTS: grid_counts_q <= cfg_data[3*AXIS_BITS-1:0];
				CFG_ORIGIN_X:    origin_q[0]   <= cfg_data;
				CFG_ORIGIN_Y:    origin_q[1]   <= cfg_data;
				CFG_ORIGIN_Z:    origin_q[2]   <= cfg_data;
				CFG_INV_STEP_X:  inv_q[0]      <= cfg_data;
				CFG_INV_STEP_Y:  inv_q[1]      <= cfg_data;
				CFG_INV_STEP_Z:  inv_q[2]      <= cfg_data;
				default: ;
			endcase
		end
	end

	// corner offsets from the cell base, refreshed every cycle
	always_ff @(posedge clk) begin
		plane_q <= PLANE_BITS'(nx) * PLANE_BITS'(ny);
		for (int c = 0; c < CORNERS; c++) begin
			corner_off_q[c] <= (c[2] ? OFF_BITS'(plane_q) : '0) +
				(c[1] ? OFF_BITS'(nx) : '0) + OFF_BITS'(c[0]);
		end
	end

	assign acfg[0] = '{origin: origin_q[0], inv_step: inv_q[0], count: nx};
	assign acfg[1] = '{origin: origin_q[1], inv_step: inv_q[1], count: ny};
	assign acfg[2] = '{origin: origin_q[2], inv_step: inv_q[2], count: nz};

	// advance the whole pipe unless a result word is held
	assign adv       = !v_s10 || rsp.ready;
	assign req.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			{v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10} <= '0;
		end else if (adv) begin
			v_s1  <= req.valid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= v_s3;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6 && (q_s6 == OP_QUERY);
			v_s8  <= v_s7;
			v_s9  <= v_s8;
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			q_s1     <= req.opcode;
			waddr_s1 <= req.sample_address;
			wdata_s1 <= {req.sample_hz, req.sample_hy, req.sample_hx,
				req.sample_ez, req.sample_ey, req.sample_ex};
			q_s2 <= q_s1; waddr_s2 <= waddr_s1; wdata_s2 <= wdata_s1;
			q_s3 <= q_s2; waddr_s3 <= waddr_s2; wdata_s3 <= wdata_s2;
			q_s4 <= q_s3; waddr_s4 <= waddr_s3; wdata_s4 <= wdata_s3;
			q_s5 <= q_s4; waddr_s5 <= waddr_s4; wdata_s5 <= wdata_s4;
			q_s6 <= q_s5; waddr_s6 <= waddr_s5; wdata_s6 <= wdata_s5;

			zy_s4 <= PLANE_BITS'(cell_s3[2].idx) * PLANE_BITS'(ny);
			ix_s4 <= cell_s3[0].idx;
			iy_s4 <= cell_s3[1].idx;
			ok_s4 <= cell_s3[0].ok && cell_s3[1].ok && cell_s3[2].ok;
			fx_s4 <= frac_s3[0]; fy_s4 <= frac_s3[1]; fz_s4 <= frac_s3[2];

			row_s5 <= LIN_BITS'((PLANE_BITS+1)'(zy_s4) + (PLANE_BITS+1)'(iy_s4)) *
				LIN_BITS'(nx);
			ix_s5  <= ix_s4;
			ok_s5  <= ok_s4;
			fx_s5 <= fx_s4; fy_s5 <= fy_s4; fz_s5 <= fz_s4;

			base_s6 <= row_s5 + LIN_BITS'(ix_s5);
			ok_s6   <= ok_s5;
			fx_s6 <= fx_s5; fy_s6 <= fy_s5; fz_s6 <= fz_s5;

			ok_s7 <= ok_s6 && cell_fits;
			fx_s7 <= fx_s6; fy_s7 <= fy_s6; fz_s7 <= fz_s6;
			ok_s8 <= ok_s7; fy_s8 <= fy_s7; fz_s8 <= fz_s7;
			ok_s9 <= ok_s8; fz_s9 <= fz_s8;
			ok_s10 <= ok_s9;
		end
	end

	for (genvar a = 0; a < 3; a++) begin : g_axis
		tfi_locate #(.FRAC_BITS(FRAC_BITS)) u_locate (
			.clk(clk), .en(adv), .cfg(acfg[a]),
			.pos(a == 0 ? req.pos_x : (a == 1 ? req.pos_y : req.pos_z)),
			.cell_s3(cell_s3[a]), .frac_s3(frac_s3[a]));
	end

	always_comb begin
		for (int c = 0; c < CORNERS; c++) begin
			offs[c] = base_s6 + LIN_BITS'(corner_off_q[c]);
		end
	end
	assign far_ext   = (LIN_BITS+AW)'(offs[CORNERS-1]);
	assign cell_fits = far_ext < (LIN_BITS+AW)'(GRID_DEPTH);
	assign waddr_ext = (AW+ADDR_IN_BITS)'(waddr_s6);
	// drop writes beyond the store
	assign ram_we = adv && v_s6 && (q_s6 == OP_WRITE) &&
		(waddr_ext < (AW+ADDR_IN_BITS)'(GRID_DEPTH));

	for (genvar c = 0; c < CORNERS; c++) begin : g_corner
		logic [AW-1:0] addr;
		assign addr = (q_s6 == OP_QUERY) ? offs[c][AW-1:0] : waddr_ext[AW-1:0];
		tfi_ram #(.WIDTH(DW), .DEPTH(GRID_DEPTH)) u_ram (
			.clk(clk), .we(ram_we), .re(adv), .addr(addr), .wdata(wdata_s6),
			.rdata(ram_q[c]));
	end

	for (genvar k = 0; k < COMPONENTS; k++) begin : g_comp
		logic signed [SAMPLE_BITS-1:0] corner [CORNERS];
		for (genvar c = 0; c < CORNERS; c++) begin : g_pick
			assign corner[c] = ram_q[c][k*SAMPLE_BITS +: SAMPLE_BITS];
		end
		tfi_blend #(.SAMPLE_BITS(SAMPLE_BITS), .FRAC_BITS(FRAC_BITS)) u_blend (
			.clk(clk), .en(adv), .corner(corner), .fx(fx_s7), .fy(fy_s8), .fz(fz_s9),
			.res(res_s10[k]));
	end

	// merge: an out-of-range cell gives zero fields
	assign rsp.valid    = v_s10;
	assign rsp.in_range = ok_s10;
	assign rsp.e_x_out  = ok_s10 ? res_s10[0] : '0;
	assign rsp.e_y_out  = ok_s10 ? res_s10[1] : '0;
	assign rsp.e_z_out  = ok_s10 ? res_s10[2] : '0;
	assign rsp.b_x_out  = ok_s10 ? res_s10[3] : '0;
	assign rsp.b_y_out  = ok_s10 ? res_s10[4] : '0;
	assign rsp.b_z_out  = ok_s10 ? res_s10[5] : '0;

`ifndef NO_ASSERTIONS
	a_store_write_not_query: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> !(v_s6 && (q_s6 == OP_QUERY)))
		else $error("store write while a query reads the store");
	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(v_s7) && $stable(v_s9))
		else $error("pipe moved during a stall");
	a_result_from_advance: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp.valid) |-> $past(adv) && $past(v_s9))
		else $error("result word appeared without an advancing query");
	a_write_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && v_s6 && (q_s6 == OP_WRITE) |=> !v_s7)
		else $error("write word reached the blend lanes");
`endif

endmodule
`default_nettype wire

// File: tb/sv/trilinear_field_interpolator_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trilinear_field_interpolator_unit_tb
// Fills grid samples and queries positions under several grid setups, with
// random gaps on both channels and one long result stall. Every result word
// is checked against a bit-exact trilinear predictor kept in this bench.
// ----------------------------------------------------------------------------
module trilinear_field_interpolator_unit_tb;
	import tfi_pkg::*;

	localparam int SB         = 24;
	localparam int DEPTH      = 32768;
	localparam int CYCLE_CAP  = 1000000;
	localparam int HOLD_CYCLES = 400;

	typedef struct {
		logic                     op;
		logic [ADDR_IN_BITS-1:0]  addr;
		logic signed [SB-1:0]     s[COMPONENTS];
		logic signed [31:0]       p[3];
	} field_word_t;

	typedef struct {
		logic                 in_range;
		logic signed [SB-1:0] f[COMPONENTS];
	} field_result_t;

	class field_result_board;
		field_result_t pending_fields[$];
		int errors;

		function new();
			errors = 0;
		endfunction

		task report(input string msg);
			$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		function void note_query(input field_result_t r);
			pending_fields.push_back(r);
		endfunction

		task check_result(input field_result_t got);
			field_result_t want;
			if (pending_fields.size() == 0) begin
				report("result word with no query waiting");
				return;
			end
			want = pending_fields.pop_front();
			if (got.in_range !== want.in_range)
				report($sformatf("in_range got %0b want %0b", got.in_range, want.in_range));
			for (int k = 0; k < COMPONENTS; k++)
				if (got.f[k] !== want.f[k])
					report($sformatf("component %0d got %h want %h", k, got.f[k], want.f[k]));
		endtask
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_BITS-1:0] cfg_index;
	logic [CFG_BITS-1:0] cfg_data;

	tfi_req_if #(.SAMPLE_BITS(SB)) req_ch ();
	tfi_rsp_if #(.SAMPLE_BITS(SB)) rsp_ch ();

	trilinear_field_interpolator_unit dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .req(req_ch), .rsp(rsp_ch)
	);

	field_result_board board = new();

	// shadow configuration and grid
	logic [29:0]        sh_counts;
	logic signed [31:0] sh_origin[3];
	logic [31:0]        sh_inv[3];
	logic signed [SB-1:0] grid_mem[COMPONENTS][DEPTH];
	bit written[DEPTH];

	bit tx_idle, rx_idle, hold_request;
	int cycles;

	always begin
		clk = 1'b1; #6;
		clk = 1'b0; #6;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic void locate_axis(input longint pos, input longint org,
			input longint unsigned inv, input longint unsigned n, output bit ok,
			output longint unsigned idx, output longint unsigned frac);
		longint diff;
		longint unsigned p;
		diff = pos - org;
		idx = 0;
		frac = 0;
		if (diff < 0) begin
			p = longint'(-diff) * inv;
			if (p != 0) begin
				ok = 0;
				return;
			end
		end else begin
			p = longint'(diff) * inv;
		end
		idx = p >> 32;
		frac = (p >> 16) & 64'hFFFF;
		ok = (idx + 2 <= n);
	endfunction

	function automatic longint blend(input longint a, input longint b,
			input longint unsigned f);
		longint t;
		t = a * (65536 - longint'(f)) + b * longint'(f) + 32768;
		return t >>> 16;
	endfunction

	function automatic field_result_t interpolate_query(input logic signed [31:0] px,
			input logic signed [31:0] py, input logic signed [31:0] pz,
			output longint unsigned corner[8], output bit reads);
		field_result_t r;
		longint unsigned n[3], idx[3], frac[3], base, plane;
		logic signed [31:0] pv[3];
		bit ok, all_ok;
		longint v[8], a[4], b0, b1, res;
		pv[0] = px; pv[1] = py; pv[2] = pz;
		n[0] = sh_counts[9:0]; n[1] = sh_counts[19:10]; n[2] = sh_counts[29:20];
		all_ok = 1;
		for (int ax = 0; ax < 3; ax++) begin
			locate_axis(longint'(pv[ax]), longint'(sh_origin[ax]), longint'(sh_inv[ax]),
				n[ax], ok, idx[ax], frac[ax]);
			all_ok &= ok;
		end
		r.in_range = 0;
		for (int k = 0; k < COMPONENTS; k++)
			r.f[k] = '0;
		reads = 0;
		if (!all_ok)
			return r;
		plane = n[0] * n[1];
		base = idx[0] + (idx[1] + idx[2] * n[1]) * n[0];
		corner[0] = base;               corner[1] = base + 1;
		corner[2] = base + n[0];        corner[3] = base + n[0] + 1;
		corner[4] = base + plane;       corner[5] = base + plane + 1;
		corner[6] = base + plane + n[0]; corner[7] = base + plane + n[0] + 1;
		if (corner[7] >= DEPTH)
			return r;
		reads = 1;
		r.in_range = 1;
		for (int k = 0; k < COMPONENTS; k++) begin
			for (int c = 0; c < 8; c++)
				v[c] = written[corner[c]] ? longint'(grid_mem[k][corner[c]]) : 0;
			for (int c = 0; c < 4; c++)
				a[c] = blend(v[2*c], v[2*c+1], frac[0]);
			b0 = blend(a[0], a[1], frac[1]);
			b1 = blend(a[2], a[3], frac[1]);
			res = blend(b0, b1, frac[2]);
			r.f[k] = res[SB-1:0];
		end
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			CFG_GRID_COUNTS: sh_counts = val[29:0];
			CFG_ORIGIN_X:    sh_origin[0] = val;
			CFG_ORIGIN_Y:    sh_origin[1] = val;
			CFG_ORIGIN_Z:    sh_origin[2] = val;
			CFG_INV_STEP_X:  sh_inv[0] = val;
			CFG_INV_STEP_Y:  sh_inv[1] = val;
			CFG_INV_STEP_Z:  sh_inv[2] = val;
			default: ;
		endcase
	endtask

	task automatic setup_grid(input logic [29:0] counts, input logic [31:0] ox,
			input logic [31:0] oy, input logic [31:0] oz, input logic [31:0] ix,
			input logic [31:0] iy, input logic [31:0] iz);
		write_reg(CFG_GRID_COUNTS, {2'b00, counts});
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_ORIGIN_Z, oz);
		write_reg(CFG_INV_STEP_X, ix);
		write_reg(CFG_INV_STEP_Y, iy);
		write_reg(CFG_INV_STEP_Z, iz);
	endtask

	task automatic send_word(input field_word_t w);
		int gap;
		longint unsigned corner[8];
		bit reads;
		gap = tx_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.opcode <= w.op;
		req_ch.sample_address <= w.addr;
		req_ch.sample_ex <= w.s[0];
		req_ch.sample_ey <= w.s[1];
		req_ch.sample_ez <= w.s[2];
		req_ch.sample_hx <= w.s[3];
		req_ch.sample_hy <= w.s[4];
		req_ch.sample_hz <= w.s[5];
		req_ch.pos_x <= w.p[0];
		req_ch.pos_y <= w.p[1];
		req_ch.pos_z <= w.p[2];
		do @(posedge clk); while (!req_ch.ready);
		if (w.op == OP_WRITE) begin
			for (int k = 0; k < COMPONENTS; k++)
				grid_mem[k][w.addr] = w.s[k];
			written[w.addr] = 1;
		end else begin
			board.note_query(interpolate_query(w.p[0], w.p[1], w.p[2], corner, reads));
		end
	endtask

	function automatic logic signed [SB-1:0] pick_sample();
		case ($urandom_range(0, 9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			3: return 24'hFFFFFF;
			default: return SB'($urandom);
		endcase
	endfunction

	task automatic write_sample(input int unsigned addr);
		field_word_t w;
		w.op = OP_WRITE;
		w.addr = ADDR_IN_BITS'(addr);
		for (int k = 0; k < COMPONENTS; k++)
			w.s[k] = pick_sample();
		for (int ax = 0; ax < 3; ax++)
			w.p[ax] = $urandom;
		send_word(w);
	endtask

	// fill any corner never written, so the query reads only stored samples
	task automatic query_at(input logic signed [31:0] px, input logic signed [31:0] py,
			input logic signed [31:0] pz);
		field_word_t w;
		longint unsigned corner[8];
		bit reads;
		void'(interpolate_query(px, py, pz, corner, reads));
		if (reads)
			for (int c = 0; c < 8; c++)
				if (!written[corner[c]])
					write_sample(32'(corner[c]));
		w.op = OP_QUERY;
		w.addr = ADDR_IN_BITS'($urandom);
		for (int k = 0; k < COMPONENTS; k++)
			w.s[k] = SB'($urandom);
		w.p[0] = px; w.p[1] = py; w.p[2] = pz;
		send_word(w);
	endtask

	function automatic logic signed [31:0] aim_axis(input int ax, input longint unsigned n);
		longint unsigned u;
		longint delta;
		if (sh_inv[ax] == 0 || n < 2)
			return sh_origin[ax] + $signed($urandom_range(0, 262144)) - 131072;
		u = $urandom_range(0, 32'((n - 1) * 65536));
		delta = longint'(u << 16) / longint'(sh_inv[ax]);
		if ($urandom_range(0, 19) == 0)
			delta = -delta - 1;
		return 32'(longint'(sh_origin[ax]) + delta);
	endfunction

	task automatic drain();
		req_ch.valid <= 1'b0;
		while (board.pending_fields.size() != 0)
			@(posedge clk);
		// writes carry no result word; let them clear the pipe
		repeat (16) @(posedge clk);
	endtask

	task automatic random_phase(input int queries);
		longint unsigned n[3];
		logic signed [31:0] p[3];
		n[0] = sh_counts[9:0]; n[1] = sh_counts[19:10]; n[2] = sh_counts[29:20];
		for (int q = 0; q < queries; q++) begin
			if ($urandom_range(0, 6) == 0)
				write_sample($urandom_range(0, DEPTH - 1));
			if ($urandom_range(0, 4) == 0) begin
				for (int ax = 0; ax < 3; ax++)
					p[ax] = $urandom;
			end else begin
				for (int ax = 0; ax < 3; ax++)
					p[ax] = aim_axis(ax, n[ax]);
			end
			query_at(p[0], p[1], p[2]);
		end
	endtask

	function automatic logic [31:0] pick_inv();
		case ($urandom_range(0, 3))
			0: return 32'h0001_0000;
			1: return $urandom_range(4096, 1 << 20);
			2: return $urandom_range(1 << 14, 1 << 18);
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] pick_origin();
		if ($urandom_range(0, 1))
			return $urandom;
		return $signed($urandom_range(0, 1 << 22)) - (1 << 21);
	endfunction

	// result side
	initial begin
		field_result_t got;
		int gap;
		rsp_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request) begin
				hold_request = 0;
				rsp_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				gap = rx_idle ? $urandom_range(0, 19) : 0;
				if (gap > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
			rsp_ch.ready <= 1'b1;
			do @(posedge clk); while (!rsp_ch.valid);
			got.in_range = rsp_ch.in_range;
			got.f[0] = rsp_ch.e_x_out;
			got.f[1] = rsp_ch.e_y_out;
			got.f[2] = rsp_ch.e_z_out;
			got.f[3] = rsp_ch.b_x_out;
			got.f[4] = rsp_ch.b_y_out;
			got.f[5] = rsp_ch.b_z_out;
			board.check_result(got);
		end
	end

	initial begin
		cycles = 0;
		tx_idle = 0;
		rx_idle = 0;
		hold_request = 0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		req_ch.valid <= 1'b0;
		req_ch.opcode <= OP_WRITE;
		req_ch.sample_address <= '0;
		req_ch.sample_ex <= '0;
		req_ch.sample_ey <= '0;
		req_ch.sample_ez <= '0;
		req_ch.sample_hx <= '0;
		req_ch.sample_hy <= '0;
		req_ch.sample_hz <= '0;
		req_ch.pos_x <= '0;
		req_ch.pos_y <= '0;
		req_ch.pos_z <= '0;
		sh_counts = '0;
		for (int ax = 0; ax < 3; ax++) begin
			sh_origin[ax] = '0;
			sh_inv[ax] = INV_STEP_RESET;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset setup: empty grid, everything out of range
		query_at(32'sh0000_8000, 32'sh0001_0000, 32'sh0000_0000);
		query_at(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_0000);
		drain();

		// small 4x4x4 unit grid, directed corners and edges
		setup_grid({10'd4, 10'd4, 10'd4}, 32'h0, 32'h0, 32'h0,
			32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
		query_at(32'sh0, 32'sh0, 32'sh0);
		query_at(32'sh0000_8000, 32'sh0000_8000, 32'sh0000_8000);
		query_at(32'sh0002_0000, 32'sh0002_0000, 32'sh0002_0000);
		query_at(32'sh0002_FFFF, 32'sh0001_7FFF, 32'sh0000_0001);
		query_at(32'sh0003_0000, 32'sh0, 32'sh0);
		query_at(32'shFFFF_FFFF, 32'sh0, 32'sh0);
		query_at(32'sh0, 32'sh7FFF_FFFF, 32'sh0);
		query_at(32'sh0, 32'sh0, 32'sh8000_0000);
		drain();

		// zero scale on z: negative offset folds to the first cell
		setup_grid({10'd3, 10'd5, 10'd2}, 32'sh0001_0000, 32'shFFFF_0000, 32'sh0004_0000,
			32'h0000_8000, 32'h0002_0000, 32'h0);
		query_at(32'sh0001_4000, 32'sh0000_0000, 32'sh8000_0000);
		query_at(32'sh0002_FFFF, 32'shFFFF_0000, 32'sh7FFF_FFFF);
		query_at(32'sh0000_FFFF, 32'sh0000_8000, 32'sh0004_0000);
		drain();

		// register extremes: counts far beyond the store
		setup_grid(30'h3FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
			32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF);
		query_at(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0);
		query_at(32'sh0, 32'sh0, 32'sh0);
		tx_idle = 1;
		rx_idle = 1;
		random_phase(60);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			setup_grid({10'($urandom_range(2, 16)), 10'($urandom_range(2, 24)),
				10'($urandom_range(2, 32))}, pick_origin(), pick_origin(), pick_origin(),
				pick_inv(), pick_inv(), pick_inv());
			tx_idle = (ph % 3) != 1;
			rx_idle = (ph % 3) != 2;
			if (ph == 1) begin
				tx_idle = 0;
				hold_request = 1;
			end
			random_phase(40);
			drain();
		end

		if (board.pending_fields.size() != 0)
			board.report("queries left without a result");
		if (board.errors == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
